/* hw/rtl/tss_pkg.sv */
`timescale 1ns / 1ps

package tss_pkg;

  localparam int unsigned SLOTS_DEFAULT = 16;
  localparam int unsigned ID_W = 16;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned PRIO_W = 8;

  localparam logic [1:0] KIND_CREATE  = 2'd0;
  localparam logic [1:0] KIND_YIELD   = 2'd1;
  localparam logic [1:0] KIND_DESTROY = 2'd2;
  localparam logic [1:0] KIND_SCHED   = 2'd3;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_FULL       = 2'd1;
  localparam logic [1:0] STATUS_NONE       = 2'd2;
  localparam logic [1:0] STATUS_NO_CURRENT = 2'd3;

  localparam logic [1:0] ALG_FCFS = 2'd0;
  localparam logic [1:0] ALG_RR   = 2'd1;

  typedef struct packed {
    logic [1:0]               kind;
    logic signed [PRIO_W-1:0] priority_req;
    logic [STAMP_W-1:0]       now_time;
  } cmd_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [3:0]      slot;
    logic [ID_W-1:0] thread_id;
  } res_t;

  typedef struct packed {
    logic                     we_entry;
    logic                     we_stamp;
    logic [ID_W-1:0]          id;
    logic signed [PRIO_W-1:0] prio;
    logic [STAMP_W-1:0]       stamp;
  } mem_wr_t;

  typedef struct packed {
    logic [ID_W-1:0]          id;
    logic signed [PRIO_W-1:0] prio;
    logic [STAMP_W-1:0]       stamp;
  } mem_rd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_READ,
    ST_MODR,
    ST_SCAN,
    ST_DRAIN
  } state_t;

endpackage

/* hw/rtl/tss_slot_store.sv */
`timescale 1ns / 1ps

module tss_slot_store #(
  parameter int unsigned SLOTS  = tss_pkg::SLOTS_DEFAULT,
  parameter int unsigned SLOT_W = (SLOTS > 2) ? $clog2(SLOTS) : 1
) (
  input  logic              clk,
  input  tss_pkg::mem_wr_t  wr,
  input  logic [SLOT_W-1:0] waddr,
  input  logic [SLOT_W-1:0] raddr,
  output tss_pkg::mem_rd_t  rd
);
  import tss_pkg::*;

  logic [ID_W-1:0]          id_mem    [SLOTS];
  logic signed [PRIO_W-1:0] prio_mem  [SLOTS];
  logic [STAMP_W-1:0]       stamp_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr.we_entry) begin
      id_mem[waddr]   <= wr.id;
      prio_mem[waddr] <= wr.prio;
    end
    if (wr.we_stamp) begin
      stamp_mem[waddr] <= wr.stamp;
    end
  end

  always_ff @(posedge clk) begin
    rd.id    <= id_mem[raddr];
    rd.prio  <= prio_mem[raddr];
    rd.stamp <= stamp_mem[raddr];
  end

endmodule

/* hw/rtl/thread_slot_scheduler.sv */
`timescale 1ns / 1ps
// Create searches for a free slot (rejected when the table is full). Yield and destroy read
// the current slot (rejected with no current thread). Schedule scans every slot; round robin
// with a current thread first reads its id for the start slot. One command at a time, with the
// next start taken with the result. The scan reads one slot per cycle through a single RAM port.
// Synchronous active-high reset clears the slot map and counters at once, no clear pass.
// Results are a one-cycle done strobe; the receiver cannot stall them.
module thread_slot_scheduler #(
  parameter int unsigned SLOTS  = tss_pkg::SLOTS_DEFAULT,
  parameter int unsigned SLOT_W = (SLOTS > 2) ? $clog2(SLOTS) : 1,
  parameter int unsigned LIVE_W = $clog2(SLOTS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  tss_pkg::cmd_t cmd,
  output logic          done,
  output tss_pkg::res_t result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_data
);
  import tss_pkg::*;

  // id mod SLOTS by reciprocal multiply, exact for 16-bit ids
  localparam int unsigned MOD_SH = ID_W + SLOT_W;
  localparam longint unsigned MOD_M_L = ((64'd1 << MOD_SH) + SLOTS - 1) / SLOTS;
  localparam logic [ID_W:0] MOD_M = (ID_W + 1)'(MOD_M_L);
  localparam logic [SLOT_W-1:0] LAST = SLOT_W'(SLOTS - 1);

  state_t state, state_next;

  logic [1:0]        alg;
  cmd_t              cmd_q;
  logic [SLOTS-1:0]  slot_used;
  logic [ID_W-1:0]   next_id;
  logic [SLOT_W-1:0] cur_slot;
  logic              cur_valid;
  logic [LIVE_W-1:0] live_count;
  logic [SLOT_W-1:0] cnt;
  logic [SLOT_W-1:0] s_addr;
  logic [SLOT_W-1:0] scan_slot;
  logic              scan_vld;
  logic              best_found;
  logic [SLOT_W-1:0] best_slot;
  logic [STAMP_W-1:0] best_key;
  logic [ID_W-1:0]   best_id;
  logic [ID_W-1:0]   cur_id;
  logic [ID_W-1:0]   tmp_id;
  logic [ID_W-1:0]   mod_q;

  mem_wr_t           mwr;
  mem_rd_t           mrd;
  logic [SLOT_W-1:0] waddr;
  logic [SLOT_W-1:0] raddr;

  logic              accept;
  logic              full;
  logic              slot_free;
  logic              cand;
  logic              better;
  logic [STAMP_W-1:0] cand_key;
  logic              best_found_upd;
  logic [SLOT_W-1:0] best_slot_upd;
  logic [ID_W-1:0]   best_id_upd;
  logic [ID_W-1:0]   cur_id_upd;
  logic [2*ID_W:0]   mod_prod;
  logic [ID_W-1:0]   mod_rem;

  tss_slot_store #(
    .SLOTS  (SLOTS),
    .SLOT_W (SLOT_W)
  ) u_store (
    .clk   (clk),
    .wr    (mwr),
    .waddr (waddr),
    .raddr (raddr),
    .rd    (mrd)
  );

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && (state == ST_IDLE);
  assign full      = (live_count == LIVE_W'(SLOTS));
  assign slot_free = !slot_used[cnt];

  // shared compare unit: priority mapped so a smaller key is a better slot
  always_comb begin
    if (alg[1]) begin
      cand_key = {{(STAMP_W - PRIO_W){1'b0}}, mrd.prio[PRIO_W-1], ~mrd.prio[PRIO_W-2:0]};
    end else begin
      cand_key = mrd.stamp;
    end
    cand   = scan_vld && slot_used[scan_slot] && !(cur_valid && (scan_slot == cur_slot));
    better = cand && (!best_found || (cand_key < best_key));
    best_found_upd = best_found || cand;
    best_slot_upd  = better ? scan_slot : best_slot;
    best_id_upd    = better ? mrd.id : best_id;
    cur_id_upd     = (scan_vld && (scan_slot == cur_slot)) ? mrd.id : cur_id;
  end

  assign mod_prod = {{(ID_W){1'b0}}, mrd.id} * {{(ID_W){1'b0}}, MOD_M};
  assign mod_rem  = tmp_id - ID_W'(mod_q * ID_W'(SLOTS));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (cmd.kind)
            KIND_CREATE:  state_next = full ? ST_IDLE : ST_FIND;
            KIND_YIELD,
            KIND_DESTROY: state_next = cur_valid ? ST_READ : ST_IDLE;
            default:      state_next = (alg == ALG_RR && cur_valid) ? ST_READ : ST_SCAN;
          endcase
        end
      end
      ST_FIND:  state_next = slot_free ? ST_IDLE : ST_FIND;
      ST_READ:  state_next = (cmd_q.kind == KIND_SCHED) ? ST_MODR : ST_IDLE;
      ST_MODR:  state_next = ST_SCAN;
      ST_SCAN:  state_next = (cnt == LAST) ? ST_DRAIN : ST_SCAN;
      ST_DRAIN: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mwr.we_entry = 1'b0;
    mwr.we_stamp = 1'b0;
    mwr.id       = next_id;
    mwr.prio     = cmd_q.priority_req;
    mwr.stamp    = cmd_q.now_time;
    waddr        = cur_slot;
    raddr        = cur_slot;
    case (state)
      ST_FIND: begin
        waddr = cnt;
        if (slot_free) begin
          mwr.we_entry = 1'b1;
          mwr.we_stamp = 1'b1;
          mwr.stamp    = '0;
        end
      end
      ST_READ: begin
        if (cmd_q.kind == KIND_YIELD && alg != ALG_FCFS) begin
          mwr.we_stamp = 1'b1;
        end
      end
      ST_SCAN: raddr = s_addr;
      default: raddr = cur_slot;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      alg        <= ALG_FCFS;
      slot_used  <= '0;
      next_id    <= ID_W'(1);
      cur_slot   <= '0;
      cur_valid  <= 1'b0;
      live_count <= '0;
      done       <= 1'b0;
      scan_vld   <= 1'b0;
      best_found <= 1'b0;
    end else begin
      state    <= state_next;
      done     <= 1'b0;
      scan_vld <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        alg <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_q      <= cmd;
            cnt        <= '0;
            s_addr     <= '0;
            best_found <= 1'b0;
            if (cmd.kind == KIND_CREATE && full) begin
              done          <= 1'b1;
              result.status <= STATUS_FULL;
              result.slot   <= '0;
              result.thread_id <= '0;
            end
            if ((cmd.kind == KIND_YIELD || cmd.kind == KIND_DESTROY) && !cur_valid) begin
              done          <= 1'b1;
              result.status <= STATUS_NO_CURRENT;
              result.slot   <= '0;
              result.thread_id <= '0;
            end
          end
        end
        ST_FIND: begin
          if (slot_free) begin
            slot_used[cnt] <= 1'b1;
            next_id        <= next_id + ID_W'(1);
            live_count     <= live_count + LIVE_W'(1);
            done           <= 1'b1;
            result.status  <= STATUS_OK;
            result.slot    <= 4'(cnt);
            result.thread_id <= next_id;
          end else begin
            cnt <= cnt + SLOT_W'(1);
          end
        end
        ST_READ: begin
          tmp_id <= mrd.id;
          mod_q  <= ID_W'(mod_prod >> MOD_SH);
          if (cmd_q.kind != KIND_SCHED) begin
            done          <= 1'b1;
            result.status <= STATUS_OK;
            result.slot   <= 4'(cur_slot);
            result.thread_id <= mrd.id;
            if (cmd_q.kind == KIND_DESTROY) begin
              slot_used[cur_slot] <= 1'b0;
              cur_valid <= 1'b0;
              if (live_count != '0) begin
                live_count <= live_count - LIVE_W'(1);
              end
            end
          end
        end
        ST_MODR: begin
          s_addr <= SLOT_W'(mod_rem);
        end
        ST_SCAN: begin
          scan_vld   <= 1'b1;
          scan_slot  <= s_addr;
          s_addr     <= (s_addr == LAST) ? '0 : s_addr + SLOT_W'(1);
          cnt        <= cnt + SLOT_W'(1);
          best_found <= best_found_upd;
          best_slot  <= best_slot_upd;
          best_key   <= better ? cand_key : best_key;
          best_id    <= best_id_upd;
          cur_id     <= cur_id_upd;
        end
        ST_DRAIN: begin
          done <= 1'b1;
          if (best_found_upd) begin
            cur_slot      <= best_slot_upd;
            cur_valid     <= 1'b1;
            result.status <= STATUS_OK;
            result.slot   <= 4'(best_slot_upd);
            result.thread_id <= best_id_upd;
          end else if (cur_valid && slot_used[cur_slot]) begin
            result.status <= STATUS_OK;
            result.slot   <= 4'(cur_slot);
            result.thread_id <= cur_id_upd;
          end else begin
            result.status <= STATUS_NONE;
            result.slot   <= '0;
            result.thread_id <= '0;
          end
        end
        default: begin
          cnt <= cnt;
        end
      endcase
    end
  end

endmodule
